### hw/rtl/uvs_pkg.sv
// Shared types and constants of the unique value stack.
`default_nettype none
package uvs_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int COUNT_OUT_W   = 7;

    // Request codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [VALUE_W-1:0]    probe;
    } cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/unique_value_stack.sv
// Top level of the unique value stack: request sequencer, cell chain and ports.
`default_nettype none
// The stack is a chain of DEPTH cells with the top of stack in cell 0. A push
// shifts every entry one cell down and loads the new value into cell 0; a pop
// shifts every entry one cell up and returns what cell 0 held; a clear drops
// the valid bit of every cell at once. Each request passes through the accept
// cycle, a compare cycle in which every cell compares its own entry with the
// request value and registers the match, and an apply cycle in which the
// matches are combined, the outcome is decided and the chain shifts. A new
// request is taken only once the one before it has been applied. The result
// sits in an output register, so the next request is accepted while an
// earlier result still waits to be taken; the apply cycle waits only while
// that register is full and its result is not being taken. Status codes:
// 0 pushed, 1 duplicate rejected, 2 full rejected, 3 popped, 4 empty pop or
// clear. A full stack rejects a push before the duplicate check is made.
// Mode 3 behaves as a clear. Entry count shows the low 7 bits of the count.
module unique_value_stack #(
    parameter int DEPTH = uvs_pkg::DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel. s_tdata: mode [1:0], value [33:2], zero [39:34].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // Result channel. m_tdata: status [2:0], popped_value [34:3],
    // running_sum [66:35], entry_count [73:67], zero [79:74].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,
    // Configuration port. Register 0 (byte address 0): unique_mode in bit 0.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = uvs_pkg::VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    state_t                          state_reg;
    logic                            unique_mode_reg;
    logic [uvs_pkg::MODE_W-1:0]      req_mode_reg;
    logic [VW-1:0]                   req_value_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [VW-1:0]                   total_reg;
    logic [VW-1:0]                   total_next;
    logic                            m_tvalid_reg;
    logic [uvs_pkg::STATUS_W-1:0]    out_status_reg;
    logic [uvs_pkg::STATUS_W-1:0]    status_next;
    logic [VW-1:0]                   out_popped_reg;
    logic [VW-1:0]                   popped_next;
    logic [VW-1:0]                   out_sum_reg;
    logic [CW-1:0]                   out_count_reg;
    logic [31:0]                     count_wide;

    logic                            s_accept;
    logic                            apply_go;
    logic                            cfg_write;
    logic                            dup_hit;
    uvs_pkg::cell_op_t               op_next;
    uvs_pkg::cell_cmd_t              cell_cmd;

    logic [VW-1:0] cell_data  [DEPTH];
    logic          cell_valid [DEPTH];
    logic [DEPTH-1:0] hit_vec;

    // ---------------------------------------------------------------
    // Configuration port: writes complete in the access cycle.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unique_mode_reg <= 1'b1;
        end else if (cfg_write && (paddr[2] == 1'b0)) begin
            unique_mode_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'b0) begin
            prdata[0] = unique_mode_reg;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain. Cell 0 is the top of stack; a push feeds it the request
    // value, and the bottom cell pulls an empty slot on a pop.
    // ---------------------------------------------------------------
    assign cell_cmd.op    = op_next;
    assign cell_cmd.probe = req_value_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VW-1:0] above_d;
        logic          above_v;
        logic [VW-1:0] below_d;
        logic          below_v;

        if (i == 0) begin : g_top
            assign above_d = req_value_reg;
            assign above_v = 1'b1;
        end else begin : g_mid_up
            assign above_d = cell_data[i-1];
            assign above_v = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign below_d = '0;
            assign below_v = 1'b0;
        end else begin : g_mid_down
            assign below_d = cell_data[i+1];
            assign below_v = cell_valid[i+1];
        end

        uvs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd),
            .above_data  (above_d),
            .above_valid (above_v),
            .below_data  (below_d),
            .below_valid (below_v),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .hit         (hit_vec[i])
        );
    end

    // Matches were registered in the compare cycle; the chain has not moved.
    assign dup_hit = |hit_vec;

    // ---------------------------------------------------------------
    // Request sequencer.
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign apply_go = (state_reg == S_APPLY) && (!m_tvalid_reg || m_tready);

    // Decide the outcome of the held request.
    always_comb begin
        op_next     = uvs_pkg::CELL_HOLD;
        status_next = uvs_pkg::ST_EMPTY;
        popped_next = '0;
        count_next  = count_reg;
        total_next  = total_reg;
        if (apply_go) begin
            priority if (req_mode_reg[1]) begin
                op_next     = uvs_pkg::CELL_CLEAR;
                status_next = uvs_pkg::ST_EMPTY;
                count_next  = '0;
                total_next  = '0;
            end else if (req_mode_reg == uvs_pkg::MODE_PUSH) begin
                priority if (count_reg == CW'(DEPTH)) begin
                    status_next = uvs_pkg::ST_FULL;
                end else if (unique_mode_reg && dup_hit) begin
                    status_next = uvs_pkg::ST_DUP;
                end else begin
                    op_next     = uvs_pkg::CELL_PUSH;
                    status_next = uvs_pkg::ST_PUSHED;
                    count_next  = count_reg + CW'(1);
                    total_next  = total_reg + req_value_reg;
                end
            end else begin
                if (count_reg == '0) begin
                    status_next = uvs_pkg::ST_EMPTY;
                    popped_next = '1;
                end else begin
                    op_next     = uvs_pkg::CELL_POP;
                    status_next = uvs_pkg::ST_POPPED;
                    popped_next = cell_data[0];
                    count_next  = count_reg - CW'(1);
                    total_next  = total_reg - cell_data[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (apply_go) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            count_reg <= count_next;
            total_reg <= total_next;

            if (apply_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_mode_reg  <= s_tdata[1:0];
            req_value_reg <= s_tdata[33:2];
        end
        if (apply_go) begin
            out_status_reg <= status_next;
            out_popped_reg <= popped_next;
            out_sum_reg    <= total_next;
            out_count_reg  <= count_next;
        end
    end

    assign count_wide = 32'(out_count_reg);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {6'd0, count_wide[6:0], out_sum_reg, out_popped_reg, out_status_reg};

endmodule
`default_nettype wire

### hw/rtl/uvs_cell.sv
// One stack cell: holds an entry, shifts with its neighbors, compares with the probe.
`default_nettype none
module uvs_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire uvs_pkg::cell_cmd_t         cmd,
    input  wire logic [uvs_pkg::VALUE_W-1:0] above_data,
    input  wire logic                       above_valid,
    input  wire logic [uvs_pkg::VALUE_W-1:0] below_data,
    input  wire logic                       below_valid,
    output logic      [uvs_pkg::VALUE_W-1:0] data,
    output logic                            valid,
    output logic                            hit
);

    logic [uvs_pkg::VALUE_W-1:0] data_reg;
    logic                        valid_reg;
    logic                        hit_reg;

    // Entry payload needs no reset; the valid bit guards it.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            uvs_pkg::CELL_PUSH: data_reg <= above_data;
            uvs_pkg::CELL_POP:  data_reg <= below_data;
            default:            data_reg <= data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            unique case (cmd.op)
                uvs_pkg::CELL_PUSH:  valid_reg <= above_valid;
                uvs_pkg::CELL_POP:   valid_reg <= below_valid;
                uvs_pkg::CELL_CLEAR: valid_reg <= 1'b0;
                default:             valid_reg <= valid_reg;
            endcase
            hit_reg <= valid_reg && (data_reg == cmd.probe);
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule
`default_nettype wire

### hw/rtl/uvs_checker.sv
// Port-level checker for the unique value stack, bound to the top level.
`default_nettype none
module uvs_port_checks (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= uvs_pkg::ST_EMPTY))
        else $error("undefined status code");

    // A push result (pushed, duplicate or full) reports a zero popped value.
    a_push_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == uvs_pkg::ST_PUSHED ||
                     m_tdata[2:0] == uvs_pkg::ST_DUP ||
                     m_tdata[2:0] == uvs_pkg::ST_FULL) |-> (m_tdata[34:3] == 32'd0))
        else $error("nonzero popped value on a push");

    // An empty pop or a clear leaves the stack empty with a zero sum.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == uvs_pkg::ST_EMPTY) |->
            (m_tdata[73:67] == 7'd0) && (m_tdata[66:35] == 32'd0))
        else $error("empty status with entries held");

endmodule

bind unique_value_stack uvs_port_checks u_uvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### bench/uvs_checker.sv
// Checker for the unique value stack: tracks requests and compares every result.
`timescale 1ns / 1ps
module uvs_checker #(
    parameter int         DEPTH            = uvs_pkg::DEPTH_DEFAULT,
    parameter logic [2:0] UNIQUE_MODE_ADDR = 3'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          pending,
    output int          failures
);

    localparam int COUNT_W = uvs_pkg::COUNT_OUT_W;

    typedef struct packed {
        logic [uvs_pkg::STATUS_W-1:0] status;
        logic [uvs_pkg::VALUE_W-1:0]  popped;
        logic [uvs_pkg::VALUE_W-1:0]  sum;
        logic [COUNT_W-1:0]           count;
    } stack_reply_t;

    logic [uvs_pkg::VALUE_W-1:0] held_values [DEPTH];
    int                          held_count = 0;
    logic [uvs_pkg::VALUE_W-1:0] held_sum   = '0;
    logic                        unique_on  = 1'b1;
    stack_reply_t                awaited_replies [$];
    int                          error_total = 0;

    function automatic bit already_held(input logic [uvs_pkg::VALUE_W-1:0] val);
        for (int i = 0; i < held_count; i++) begin
            if (held_values[i] == val) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow stack and queues the result it must give.
    task automatic apply_request(input logic [uvs_pkg::MODE_W-1:0] op,
                                 input logic [uvs_pkg::VALUE_W-1:0] val);
        stack_reply_t r;
        r.popped = '0;
        if (op == uvs_pkg::MODE_PUSH) begin
            if (held_count >= DEPTH) begin
                r.status = uvs_pkg::ST_FULL;
            end else if (unique_on && already_held(val)) begin
                r.status = uvs_pkg::ST_DUP;
            end else begin
                held_values[held_count] = val;
                held_count++;
                held_sum += val;
                r.status = uvs_pkg::ST_PUSHED;
            end
        end else if (op == uvs_pkg::MODE_POP) begin
            if (held_count == 0) begin
                r.popped = '1;
                r.status = uvs_pkg::ST_EMPTY;
            end else begin
                held_count--;
                r.popped = held_values[held_count];
                held_sum -= r.popped;
                r.status = uvs_pkg::ST_POPPED;
            end
        end else begin
            // Clear and the spare code both empty the stack.
            held_count = 0;
            held_sum   = '0;
            r.status   = uvs_pkg::ST_EMPTY;
        end
        r.sum   = held_sum;
        r.count = COUNT_W'(held_count);
        awaited_replies.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            error_total++;
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want),
                     $signed(got));
        end
    endtask

    always @(posedge aclk) begin : watch
        stack_reply_t want;
        if (!aresetn) begin
            held_count = 0;
            held_sum   = '0;
            unique_on  = 1'b1;
            awaited_replies.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == UNIQUE_MODE_ADDR) begin
                unique_on = pwdata[0];
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tdata[1:0], s_tdata[33:2]);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_replies.size() == 0) begin
                    error_total++;
                    $display("%0t: result with no request waiting, m_tdata %h", $time, m_tdata);
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
                    check_field("popped_value", want.popped, m_tdata[34:3]);
                    check_field("running_sum", want.sum, m_tdata[66:35]);
                    check_field("entry_count", 32'(want.count), 32'(m_tdata[73:67]));
                end
            end
            pending <= awaited_replies.size();
        end
        failures <= error_total;
    end

endmodule

### bench/testbench.sv
// Testbench top for the unique value stack: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;

    // Register map: unique_mode is register 0.
    localparam logic [2:0] ADDR_UNIQUE_MODE = 3'd0;
    // The fourth mode code is unused by the block and decodes as a clear.
    localparam logic [uvs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 115;

    // Receiver behavior for one stretch of cycles.
    typedef enum int {RX_FREE, RX_RANDOM, RX_CHOKED} rx_style_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int failures;

    // Sender burst bookkeeping and the last value pushed, reused to provoke duplicates.
    int          burst_left = 0;
    logic [31:0] last_value = '0;

    // Receiver stall pattern state.
    rx_style_t rx_style = RX_FREE;
    int        rx_left  = 0;

    always begin
        #1;
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
    end

    unique_value_stack u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    uvs_checker #(
        .DEPTH            (uvs_pkg::DEPTH_DEFAULT),
        .UNIQUE_MODE_ADDR (ADDR_UNIQUE_MODE)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pending  (pending),
        .failures (failures)
    );

    // The result side switches between stretches of free flow, coin-flip stalls
    // and heavy back-pressure, each of random length, so stalls land on every
    // state of the request sequencer.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 2));
            rx_left  = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_style)
            RX_FREE: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Values for push requests: mostly full-range random, with a share drawn from
    // a tiny pool around zero, the 32-bit extremes and repeats of the last push,
    // so that the duplicate check fires often when unique mode is on.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom();
            6, 7: return 32'(int'($urandom_range(0, 7)) - 4);
            8: return last_value;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Offers one request and returns in the time step of the edge that took it.
    // Requests go out in bursts; between bursts s_tvalid drops for a random gap,
    // and sometimes the gap is zero so bursts run back to back.
    task automatic send_request(input logic [uvs_pkg::MODE_W-1:0] op,
                                input logic [uvs_pkg::VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, op};
        if (op == uvs_pkg::MODE_PUSH) last_value = val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Stops offering requests and waits until every result has come back. The
    // first edge lets the checker count the request taken at the edge just passed.
    task automatic wait_for_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Register write: a setup phase, then access until pready. Upper data bits
    // carry random junk, since only bit 0 of the register is implemented.
    task automatic write_unique_mode(input logic enable);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_UNIQUE_MODE;
        pwdata  <= {31'($urandom()), enable};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int fill_len;
        int push_weight;
        int pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, unique mode on. The extremes are pushed first so the
        // running sum wraps, then duplicates of stored values are refused, the
        // stack is drained past empty, and both clear codes are exercised.
        write_unique_mode(1'b1);
        send_request(uvs_pkg::MODE_PUSH, 32'h8000_0000);
        send_request(uvs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_request(uvs_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(uvs_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_request(uvs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_request(uvs_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_PUSH, 32'h0000_0005);
        send_request(uvs_pkg::MODE_PUSH, 32'h0000_0005);
        send_request(uvs_pkg::MODE_CLEAR, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_PUSH, 32'h5555_AAAA);
        send_request(MODE_SPARE, $urandom());
        send_request(uvs_pkg::MODE_CLEAR, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());

        // With unique mode off the same value may be stored twice.
        wait_for_results();
        write_unique_mode(1'b0);
        send_request(uvs_pkg::MODE_PUSH, 32'hAAAA_5555);
        send_request(uvs_pkg::MODE_PUSH, 32'hAAAA_5555);
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());
        send_request(uvs_pkg::MODE_POP, $urandom());

        // Random phases alternate the mode. Each one opens with a run of pushes
        // long enough to fill the stack most of the time, so full rejections and
        // deep duplicate searches get exercised, then mixes all request kinds
        // with a push share that differs from phase to phase.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_results();
            write_unique_mode(ph % 2 == 0);
            fill_len    = $urandom_range(40, 90);
            push_weight = $urandom_range(35, 80);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n < fill_len) begin
                    send_request(uvs_pkg::MODE_PUSH,
                                 ($urandom_range(0, 4) == 0) ? pick_value() : $urandom());
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < push_weight) begin
                        send_request(uvs_pkg::MODE_PUSH, pick_value());
                    end else if (pick < 97) begin
                        send_request(uvs_pkg::MODE_POP, $urandom());
                    end else if (pick < 99) begin
                        send_request(uvs_pkg::MODE_CLEAR, $urandom());
                    end else begin
                        send_request(MODE_SPARE, $urandom());
                    end
                end
            end
        end

        // Drain, then let any stray result show before the verdict.
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

endmodule
